>>> rtl/core/sphere_penalty_contact_force_defines.svh
// ----------------------------------------------------------------------------
// sphere_penalty_contact_force_defines.svh
// Assertion macros shared by the sphere contact force block.
// ----------------------------------------------------------------------------
`ifndef SPHERE_PENALTY_CONTACT_FORCE_DEFINES_SVH
`define SPHERE_PENALTY_CONTACT_FORCE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked outside reset
`define SPCF_ASSERT_IMPLIES(lbl, clk_i, rstn_i, ante, cons) \
    lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
        else $error("spcf: implication check failed");

// next-cycle implication, checked outside reset
`define SPCF_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons) \
    lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
        else $error("spcf: next-cycle check failed");

`else

`define SPCF_ASSERT_IMPLIES(lbl, clk_i, rstn_i, ante, cons)

`define SPCF_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons)

`endif

`endif

>>> rtl/core/spcf_pkg.sv
// ----------------------------------------------------------------------------
// spcf_pkg
// Shared constants, register codes and item types of the sphere contact block.
// ----------------------------------------------------------------------------
package spcf_pkg;

    // queue between front and back
    localparam int QDEPTH       = 8;
    localparam int QPTR_W       = $clog2(QDEPTH);
    localparam int QCNT_W       = $clog2(QDEPTH + 1);
    localparam int FRONT_STAGES = 4;

    // back-end unit depths
    localparam int SQRT_STAGES = 32;
    localparam int DIV_STEPS   = 33;
    localparam int DIV_STAGES  = DIV_STEPS + 1;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_CENTER_X   = 3'd0,
        CFG_CENTER_Y   = 3'd1,
        CFG_CENTER_Z   = 3'd2,
        CFG_RADIUS     = 3'd3,
        CFG_STIFFNESS  = 3'd4,
        CFG_LOAD_SCALE = 3'd5
    } cfg_index_t;

    // per-node tag carried alongside the distance computation
    typedef struct packed {
        logic [11:0]      node;
        logic             last;
        logic [2:0]       neg;
        logic [2:0][31:0] mag;
    } tag_t;

    // queue entry: tag plus squared distance
    typedef struct packed {
        tag_t        tag;
        logic [63:0] sum;
    } item_t;

    // side info carried through the divider
    typedef struct packed {
        logic [11:0] node;
        logic        last;
        logic [2:0]  neg;
        logic [31:0] gap;
        logic        contact;
        logic        degen;
    } side_t;

    // finished result
    typedef struct packed {
        logic [11:0]      node;
        logic [2:0][31:0] force_v;
        logic [31:0]      gap;
        logic             contact;
        logic             degen;
        logic             sat;
        logic             last;
    } result_t;

endpackage

>>> rtl/core/sphere_penalty_contact_force.sv
// ----------------------------------------------------------------------------
// sphere_penalty_contact_force
// Path: front stages, queue, square root, back stages and divider; done is registered
// together with the result.
// Throughput: one node per cycle while busy is low, set by the fully pipelined root and divider.
// busy stays low in normal streaming; the result port cannot be stalled.
// Reset: async active-low; clears the pipeline valids and the configuration registers (scale 1.0).
// ----------------------------------------------------------------------------
`include "sphere_penalty_contact_force_defines.svh"

module sphere_penalty_contact_force import spcf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [11:0] node_index,
    input  logic [31:0] ref_x,
    input  logic [31:0] ref_y,
    input  logic [31:0] ref_z,
    input  logic [31:0] disp_x,
    input  logic [31:0] disp_y,
    input  logic [31:0] disp_z,
    input  logic        last_node,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output logic        done,
    output logic [11:0] node_out,
    output logic [31:0] force_x,
    output logic [31:0] force_y,
    output logic [31:0] force_z,
    output logic [31:0] gap,
    output logic        in_contact,
    output logic        degenerate,
    output logic        saturated,
    output logic        last_out
);

    logic [31:0]       center_x_reg;
    logic [31:0]       center_y_reg;
    logic [31:0]       center_z_reg;
    logic [30:0]       radius_reg;
    logic [30:0]       stiffness_reg;
    logic [30:0]       load_scale_reg;
    logic [61:0]       k_reg;

    logic              accept;
    logic              push;
    item_t             push_item;
    logic              pop;
    item_t             pop_item;
    logic [QCNT_W-1:0] q_count;
    result_t           result;

    logic              free_node;
    logic              forces_zero;
    logic              scale_we;

    assign accept = start && !busy;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg   <= '0;
            center_y_reg   <= '0;
            center_z_reg   <= '0;
            radius_reg     <= '0;
            stiffness_reg  <= '0;
            load_scale_reg <= 31'd65536;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CENTER_X:   center_x_reg   <= cfg_data;
                CFG_CENTER_Y:   center_y_reg   <= cfg_data;
                CFG_CENTER_Z:   center_z_reg   <= cfg_data;
                CFG_RADIUS:     radius_reg     <= cfg_data[30:0];
                CFG_STIFFNESS:  stiffness_reg  <= cfg_data[30:0];
                CFG_LOAD_SCALE: load_scale_reg <= cfg_data[30:0];
                default:        ;
            endcase
        end
    end

    // stiffness times scale, refreshed every cycle
    always_ff @(posedge clk)
    begin
        k_reg <= 62'(stiffness_reg) * 62'(load_scale_reg);
    end

    spcf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .node_index (node_index),
        .ref_x      (ref_x),
        .ref_y      (ref_y),
        .ref_z      (ref_z),
        .disp_x     (disp_x),
        .disp_y     (disp_y),
        .disp_z     (disp_z),
        .last_node  (last_node),
        .center_x   (center_x_reg),
        .center_y   (center_y_reg),
        .center_z   (center_z_reg),
        .push       (push),
        .push_item  (push_item)
    );

    spcf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .busy      (busy),
        .count     (q_count)
    );

    spcf_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pop),
        .in_item  (pop_item),
        .radius   (radius_reg),
        .k_prod   (k_reg),
        .done     (done),
        .result   (result)
    );

    assign node_out   = result.node;
    assign force_x    = result.force_v[0];
    assign force_y    = result.force_v[1];
    assign force_z    = result.force_v[2];
    assign gap        = result.gap;
    assign in_contact = result.contact;
    assign degenerate = result.degen;
    assign saturated  = result.sat;
    assign last_out   = result.last;

    // terms used by the checks
    assign free_node   = !in_contact || degenerate;
    assign forces_zero = (force_x == 32'd0) && (force_y == 32'd0) && (force_z == 32'd0);
    assign scale_we    = cfg_we && (cfg_index == CFG_LOAD_SCALE);

    // checks
    `SPCF_ASSERT_IMPLIES(a_q_no_overrun, clk, rst_n, push && !pop, q_count < QCNT_W'(QDEPTH))
    `SPCF_ASSERT_IMPLIES(a_contact_sign, clk, rst_n, done, in_contact == gap[31])
    `SPCF_ASSERT_IMPLIES(a_free_quiet, clk, rst_n, done && free_node, !saturated && forces_zero)
    `SPCF_ASSERT_NEXT(a_scale_write, clk, rst_n, scale_we, load_scale_reg == $past(cfg_data[30:0]))

endmodule

>>> rtl/core/spcf_front.sv
// ----------------------------------------------------------------------------
// spcf_front
// Front end: takes a node, forms the offset from the centre, its magnitudes
// and the squared distance, and pushes the item into the queue.
// ----------------------------------------------------------------------------
module spcf_front import spcf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [11:0] node_index,
    input  logic [31:0] ref_x,
    input  logic [31:0] ref_y,
    input  logic [31:0] ref_z,
    input  logic [31:0] disp_x,
    input  logic [31:0] disp_y,
    input  logic [31:0] disp_z,
    input  logic        last_node,
    input  logic [31:0] center_x,
    input  logic [31:0] center_y,
    input  logic [31:0] center_z,
    output logic        push,
    output item_t       push_item
);

    logic [2:0][31:0] ref_v;
    logic [2:0][31:0] disp_v;
    logic [2:0][31:0] ctr_v;

    logic                    f1_vld_reg;
    logic signed [32:0]      f1_pos_reg [3];
    logic [11:0]             f1_node_reg;
    logic                    f1_last_reg;

    logic                    f2_vld_reg;
    logic [31:0]             f2_v_reg [3];
    logic [11:0]             f2_node_reg;
    logic                    f2_last_reg;

    logic                    f3_vld_reg;
    logic [63:0]             f3_sq_reg [3];
    tag_t                    f3_tag_reg;

    logic                    f4_vld_reg;
    item_t                   f4_item_reg;

    logic signed [33:0]      diff [3];
    logic [31:0]             v_next [3];
    logic [31:0]             mag_next [3];
    logic [63:0]             sq_next [3];

    assign ref_v  = {ref_z, ref_y, ref_x};
    assign disp_v = {disp_z, disp_y, disp_x};
    assign ctr_v  = {center_z, center_y, center_x};

    // offset from centre, clamped to 32 bits
    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            diff[l] = {f1_pos_reg[l][32], f1_pos_reg[l]} - {{2{ctr_v[l][31]}}, ctr_v[l]};
            if ((diff[l][33:31] == 3'b000) || (diff[l][33:31] == 3'b111))
            begin
                v_next[l] = diff[l][31:0];
            end
            else if (diff[l][33])
            begin
                v_next[l] = 32'h8000_0000;
            end
            else
            begin
                v_next[l] = 32'h7FFF_FFFF;
            end
        end
    end

    // magnitude and square per axis
    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            mag_next[l] = f2_v_reg[l][31] ? (32'd0 - f2_v_reg[l]) : f2_v_reg[l];
            sq_next[l]  = 64'(mag_next[l]) * 64'(mag_next[l]);
        end
    end

    // advance stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_vld_reg <= 1'b0;
            f2_vld_reg <= 1'b0;
            f3_vld_reg <= 1'b0;
            f4_vld_reg <= 1'b0;
        end
        else
        begin
            f1_vld_reg <= accept;
            f2_vld_reg <= f1_vld_reg;
            f3_vld_reg <= f2_vld_reg;
            f4_vld_reg <= f3_vld_reg;
        end
    end

    // hold stage payloads
    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 3; l++)
        begin
            f1_pos_reg[l] <= $signed({ref_v[l][31], ref_v[l]}) +
                             $signed({disp_v[l][31], disp_v[l]});
            f2_v_reg[l]   <= v_next[l];
            f3_sq_reg[l]  <= sq_next[l];
            f3_tag_reg.neg[l] <= f2_v_reg[l][31];
            f3_tag_reg.mag[l] <= mag_next[l];
        end
        f1_node_reg <= node_index;
        f1_last_reg <= last_node;
        f2_node_reg <= f1_node_reg;
        f2_last_reg <= f1_last_reg;
        f3_tag_reg.node <= f2_node_reg;
        f3_tag_reg.last <= f2_last_reg;
        f4_item_reg.tag <= f3_tag_reg;
        f4_item_reg.sum <= f3_sq_reg[0] + f3_sq_reg[1] + f3_sq_reg[2];
    end

    assign push      = f4_vld_reg;
    assign push_item = f4_item_reg;

endmodule

>>> rtl/core/spcf_queue.sv
// ----------------------------------------------------------------------------
// spcf_queue
// Short FIFO between front and back; the back drains it whenever it holds an entry.
// ----------------------------------------------------------------------------
module spcf_queue import spcf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  item_t             push_item,
    output logic              pop,
    output item_t             pop_item,
    output logic              busy,
    output logic [QCNT_W-1:0] count
);

    item_t               mem [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;

    // drain whenever something is queued
    assign pop      = (count_reg != '0);
    assign pop_item = mem[rd_ptr_reg];

    // stop the front before its in-flight items could overrun the queue
    assign busy  = (count_reg >= QCNT_W'(QDEPTH - FRONT_STAGES));
    assign count = count_reg;

    always_comb
    begin
        count_next = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    // advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // write storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> rtl/core/spcf_sqrt.sv
// ----------------------------------------------------------------------------
// spcf_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module spcf_sqrt import spcf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  item_t       in_item,
    output logic        out_valid,
    output tag_t        out_tag,
    output logic [31:0] out_root
);

    logic [SQRT_STAGES-1:0] vld_reg;
    logic [63:0]            rem_reg  [SQRT_STAGES];
    logic [31:0]            root_reg [SQRT_STAGES];
    tag_t                   tag_reg  [SQRT_STAGES];

    logic [63:0]            rem_in   [SQRT_STAGES];
    logic [31:0]            root_in  [SQRT_STAGES];
    tag_t                   tag_in   [SQRT_STAGES];
    logic [64:0]            trial    [SQRT_STAGES];
    logic                   take     [SQRT_STAGES];

    // stage inputs: first from the queue, rest from the previous stage
    always_comb
    begin
        rem_in[0]  = in_item.sum;
        root_in[0] = '0;
        tag_in[0]  = in_item.tag;
        for (int s = 1; s < SQRT_STAGES; s++)
        begin
            rem_in[s]  = rem_reg[s-1];
            root_in[s] = root_reg[s-1];
            tag_in[s]  = tag_reg[s-1];
        end
        // trial term (4 * root + 1) at this bit pair
        for (int s = 0; s < SQRT_STAGES; s++)
        begin
            trial[s] = ((65'(root_in[s]) << 2) | 65'd1) << (2 * (SQRT_STAGES - 1 - s));
            take[s]  = ({1'b0, rem_in[s]} >= trial[s]);
        end
    end

    // advance valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[SQRT_STAGES-2:0], in_valid};
        end
    end

    // subtract trial and shift in one root bit
    always_ff @(posedge clk)
    begin
        for (int s = 0; s < SQRT_STAGES; s++)
        begin
            rem_reg[s]  <= take[s] ? (rem_in[s] - trial[s][63:0]) : rem_in[s];
            root_reg[s] <= {root_in[s][30:0], take[s]};
            tag_reg[s]  <= tag_in[s];
        end
    end

    assign out_valid = vld_reg[SQRT_STAGES-1];
    assign out_tag   = tag_reg[SQRT_STAGES-1];
    assign out_root  = root_reg[SQRT_STAGES-1];

endmodule

>>> rtl/core/spcf_div.sv
// ----------------------------------------------------------------------------
// spcf_div
// Pipelined restoring divider, three lanes sharing one divisor.
// Flags quotients of 2^33 or more up front, then makes one bit per stage.
// ----------------------------------------------------------------------------
module spcf_div import spcf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [92:0]      num [3],
    input  logic [30:0]      den,
    input  side_t            in_side,
    output logic             out_valid,
    output logic [32:0]      quot [3],
    output logic [2:0]       ovf,
    output logic [30:0]      out_den,
    output side_t            out_side
);

    logic [DIV_STAGES-1:0] vld_reg;
    logic [30:0]           rem_reg  [DIV_STAGES][3];
    logic [32:0]           low_reg  [DIV_STAGES][3];
    logic [32:0]           q_reg    [DIV_STAGES][3];
    logic                  ovf_reg  [DIV_STAGES][3];
    logic [30:0]           den_reg  [DIV_STAGES];
    side_t                 side_reg [DIV_STAGES];

    logic [30:0]           rem_nx   [DIV_STAGES][3];
    logic [32:0]           low_nx   [DIV_STAGES][3];
    logic [32:0]           q_nx     [DIV_STAGES][3];
    logic                  ovf_nx   [DIV_STAGES][3];
    logic [31:0]           t        [DIV_STAGES][3];
    logic                  ge       [DIV_STAGES][3];

    always_comb
    begin
        // precheck: high part against divisor
        for (int l = 0; l < 3; l++)
        begin
            t[0][l]      = '0;
            ge[0][l]     = 1'b0;
            ovf_nx[0][l] = (num[l][92:33] >= 60'(den));
            rem_nx[0][l] = ovf_nx[0][l] ? 31'd0 : num[l][63:33];
            low_nx[0][l] = num[l][32:0];
            q_nx[0][l]   = '0;
        end
        // one quotient bit per stage
        for (int s = 1; s < DIV_STAGES; s++)
        begin
            for (int l = 0; l < 3; l++)
            begin
                t[s][l]      = {rem_reg[s-1][l], low_reg[s-1][l][32]};
                ge[s][l]     = (t[s][l] >= {1'b0, den_reg[s-1]});
                rem_nx[s][l] = ge[s][l] ? 31'(t[s][l] - {1'b0, den_reg[s-1]}) : t[s][l][30:0];
                low_nx[s][l] = {low_reg[s-1][l][31:0], 1'b0};
                q_nx[s][l]   = {q_reg[s-1][l][31:0], ge[s][l]};
                ovf_nx[s][l] = ovf_reg[s-1][l];
            end
        end
    end

    // advance valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[DIV_STAGES-2:0], in_valid};
        end
    end

    // hold stage payloads
    always_ff @(posedge clk)
    begin
        den_reg[0]  <= den;
        side_reg[0] <= in_side;
        for (int s = 1; s < DIV_STAGES; s++)
        begin
            den_reg[s]  <= den_reg[s-1];
            side_reg[s] <= side_reg[s-1];
        end
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            for (int l = 0; l < 3; l++)
            begin
                rem_reg[s][l] <= rem_nx[s][l];
                low_reg[s][l] <= low_nx[s][l];
                q_reg[s][l]   <= q_nx[s][l];
                ovf_reg[s][l] <= ovf_nx[s][l];
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            quot[l] = q_reg[DIV_STAGES-1][l];
            ovf[l]  = ovf_reg[DIV_STAGES-1][l];
        end
    end

    assign out_valid = vld_reg[DIV_STAGES-1];
    assign out_den   = den_reg[DIV_STAGES-1];
    assign out_side  = side_reg[DIV_STAGES-1];

endmodule

>>> rtl/core/spcf_back.sv
// ----------------------------------------------------------------------------
// spcf_back
// Back end: distance, gap, penalty products, per-axis division and the
// saturating output register.
// ----------------------------------------------------------------------------
module spcf_back import spcf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  item_t       in_item,
    input  logic [30:0] radius,
    input  logic [61:0] k_prod,
    output logic        done,
    output result_t     result
);

    logic        sq_vld;
    tag_t        sq_tag;
    logic [31:0] sq_root;

    // gap stage
    logic        b1_vld_reg;
    side_t       b1_side_reg;
    logic [30:0] b1_pen_reg;
    logic [30:0] b1_den_reg;
    logic [31:0] b1_mag_reg [3];

    // pen * stiffness * scale, low and high halves
    logic        b2_vld_reg;
    side_t       b2_side_reg;
    logic [62:0] b2_pp0_reg;
    logic [60:0] b2_pp1_reg;
    logic [30:0] b2_den_reg;
    logic [31:0] b2_mag_reg [3];

    logic        b3_vld_reg;
    side_t       b3_side_reg;
    logic [92:0] b3_p_reg;
    logic [30:0] b3_den_reg;
    logic [31:0] b3_mag_reg [3];

    // partial products with each magnitude
    logic        b4_vld_reg;
    side_t       b4_side_reg;
    logic [63:0] b4_m0_reg [3];
    logic [63:0] b4_m1_reg [3];
    logic [60:0] b4_m2_reg [3];
    logic [30:0] b4_den_reg;

    logic        b5_vld_reg;
    side_t       b5_side_reg;
    logic [92:0] b5_num_reg [3];
    logic [30:0] b5_den_reg;

    logic        dv_vld;
    logic [32:0] dv_quot [3];
    logic [2:0]  dv_ovf;
    logic [30:0] dv_den;
    side_t       dv_side;

    logic        done_reg;
    result_t     res_reg;
    result_t     res_next;

    logic signed [32:0] g_full;
    logic               contact;
    logic [124:0]       n_full [3];
    logic [32:0]        limit  [3];
    logic [2:0]         clip;
    logic [31:0]        fmag   [3];
    logic               active;

    spcf_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_item   (in_item),
        .out_valid (sq_vld),
        .out_tag   (sq_tag),
        .out_root  (sq_root)
    );

    // gap and contact test
    always_comb
    begin
        g_full  = $signed({1'b0, sq_root}) - $signed({2'b00, radius});
        contact = (sq_root < {1'b0, radius});
    end

    // full product with each magnitude
    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            n_full[l] = 125'(b4_m0_reg[l]) + (125'(b4_m1_reg[l]) << 32) +
                        (125'(b4_m2_reg[l]) << 64);
        end
    end

    // advance valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_vld_reg <= 1'b0;
            b2_vld_reg <= 1'b0;
            b3_vld_reg <= 1'b0;
            b4_vld_reg <= 1'b0;
            b5_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            b1_vld_reg <= sq_vld;
            b2_vld_reg <= b1_vld_reg;
            b3_vld_reg <= b2_vld_reg;
            b4_vld_reg <= b3_vld_reg;
            b5_vld_reg <= b4_vld_reg;
            done_reg   <= dv_vld;
        end
    end

    // hold stage payloads
    always_ff @(posedge clk)
    begin
        b1_side_reg.node    <= sq_tag.node;
        b1_side_reg.last    <= sq_tag.last;
        b1_side_reg.neg     <= sq_tag.neg;
        b1_side_reg.gap     <= (g_full > 33'sh0_7FFF_FFFF) ? 32'h7FFF_FFFF : g_full[31:0];
        b1_side_reg.contact <= contact;
        b1_side_reg.degen   <= contact && (sq_root == '0);
        b1_pen_reg          <= radius - sq_root[30:0];
        b1_den_reg          <= sq_root[30:0];

        b2_side_reg <= b1_side_reg;
        b2_pp0_reg  <= 63'(b1_pen_reg) * 63'(k_prod[31:0]);
        b2_pp1_reg  <= 61'(b1_pen_reg) * 61'(k_prod[61:32]);
        b2_den_reg  <= b1_den_reg;

        b3_side_reg <= b2_side_reg;
        b3_p_reg    <= 93'(b2_pp0_reg) + (93'(b2_pp1_reg) << 32);
        b3_den_reg  <= b2_den_reg;

        b4_side_reg <= b3_side_reg;
        b4_den_reg  <= b3_den_reg;

        b5_side_reg <= b4_side_reg;
        b5_den_reg  <= b4_den_reg;

        for (int l = 0; l < 3; l++)
        begin
            b1_mag_reg[l] <= sq_tag.mag[l];
            b2_mag_reg[l] <= b1_mag_reg[l];
            b3_mag_reg[l] <= b2_mag_reg[l];
            b4_m0_reg[l]  <= 64'(b3_p_reg[31:0]) * 64'(b3_mag_reg[l]);
            b4_m1_reg[l]  <= 64'(b3_p_reg[63:32]) * 64'(b3_mag_reg[l]);
            b4_m2_reg[l]  <= 61'(b3_p_reg[92:64]) * 61'(b3_mag_reg[l]);
            b5_num_reg[l] <= n_full[l][124:32];
        end
    end

    spcf_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (b5_vld_reg),
        .num       (b5_num_reg),
        .den       (b5_den_reg),
        .in_side   (b5_side_reg),
        .out_valid (dv_vld),
        .quot      (dv_quot),
        .ovf       (dv_ovf),
        .out_den   (dv_den),
        .out_side  (dv_side)
    );

    // clip, sign and zero the forces outside penetration or at a degenerate node
    always_comb
    begin
        active = dv_side.contact && !dv_side.degen && (dv_den != '0);
        for (int l = 0; l < 3; l++)
        begin
            limit[l] = dv_side.neg[l] ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
            clip[l]  = dv_ovf[l] || (dv_quot[l] > limit[l]);
            fmag[l]  = clip[l] ? limit[l][31:0] : dv_quot[l][31:0];
            res_next.force_v[l] = !active ? 32'd0 :
                                  (dv_side.neg[l] ? (32'd0 - fmag[l]) : fmag[l]);
        end
        res_next.node    = dv_side.node;
        res_next.gap     = dv_side.gap;
        res_next.contact = dv_side.contact;
        res_next.degen   = dv_side.degen;
        res_next.sat     = active && (clip != '0);
        res_next.last    = dv_side.last;
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule
